// ===== design/pzdm_pkg.sv =====
// ----------------------------------------------------------------------------
// pzdm_pkg
// Shared types, codes and defaults of the direction mask grid.
// ----------------------------------------------------------------------------
package pzdm_pkg;

    localparam int DEF_MAX_COLUMNS  = 256;
    localparam int DEF_MAX_ROWS     = 256;
    localparam int DEF_MAX_VERTICES = 16;

    // serial multiply: one bit of a 34-bit edge delta per cycle
    localparam int MUL_STEPS = 34;

    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_APPLY = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_ORIGIN_X    = 3'd2;
    localparam logic [2:0] CFG_ORIGIN_Y    = 3'd3;
    localparam logic [2:0] CFG_CELL_SIZE   = 3'd4;
    localparam logic [2:0] CFG_FILL_MASK   = 3'd5;

    localparam logic [8:0]  RST_GRID_WIDTH  = 9'd256;
    localparam logic [8:0]  RST_GRID_HEIGHT = 9'd256;
    localparam logic [30:0] RST_CELL_SIZE   = 31'd65536;
    localparam logic [7:0]  RST_FILL_MASK   = 8'hFF;
    localparam logic [7:0]  INIT_MASK       = 8'hFF;

    localparam logic [3:0] MAX_DIRECTION = 4'd7;
    localparam int         MIN_VERTICES  = 3;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FEW  = 2'd1,
        STATUS_FULL = 2'd2
    } pzdm_status_t;

    typedef struct packed {
        logic load;
        logic step;
        logic fin;
    } pzdm_setup_t;

    typedef struct packed {
        logic valid;
        logic row_end;
        logic last;
        logic parity;
    } pzdm_tok_t;

endpackage

// ===== design/polygon_zone_direction_mask_grid_core.sv =====
// ----------------------------------------------------------------------------
// polygon_zone_direction_mask_grid_core
// Grid of 8-bit direction masks with even-odd polygon zone fill.
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------
//  request   | start / busy         | mode, vertex_x/y, zone_mask, cell_x/y,
//            |                      | direction
//  result    | done (1-cycle pulse) | status, cell_mask, allowed
//  config    | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Request steps: add vertex answers from idle; query reads the mask RAM,
//  then answers; clear walks all MAX_COLUMNS*MAX_ROWS entries; apply runs
//  a serial setup multiply, then one grid cell per cycle down the chain of
//  edge cells, then a chain drain. Apply with fewer than three vertices or
//  an empty grid answers from idle. The mask RAM has one write port, so
//  clear walks it one entry a cycle. After reset the block runs a clearing
//  pass writing 0xFF to every entry; busy stays high meanwhile, config
//  writes are taken. Results cannot be stalled: done is shown for one cycle
//  and the next request may be accepted in that same cycle.
//
module polygon_zone_direction_mask_grid_core
    import pzdm_pkg::*;
#(
    parameter int MAX_COLUMNS  = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [31:0] vertex_x,
    input  logic [31:0] vertex_y,
    input  logic [7:0]  zone_mask,
    input  logic [7:0]  cell_x,
    input  logic [7:0]  cell_y,
    input  logic [3:0]  direction,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  cell_mask,
    output logic        allowed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int DEPTH   = MAX_COLUMNS * MAX_ROWS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CWW     = $clog2(MAX_COLUMNS + 1);
    localparam int RWW     = $clog2(MAX_ROWS + 1);
    localparam int GEW     = (CWW > 9) ? CWW : 9;
    localparam int GHW     = (RWW > 9) ? RWW : 9;
    localparam int MAX_DIM = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int PW      = $clog2(2 * MAX_DIM) + 33;
    localparam int LW      = PW + 1 + 34;
    localparam int CNTW    = $clog2(MAX_VERTICES + 1);
    localparam int QW      = 8 + CWW + AW;
    localparam int MCW     = $clog2(MUL_STEPS);

    typedef enum logic [9:0] {
        S_INIT  = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_QREAD = 10'b0000000100,
        S_QOUT  = 10'b0000001000,
        S_LOAD  = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_FIN   = 10'b0001000000,
        S_SWEEP = 10'b0010000000,
        S_DRAIN = 10'b0100000000,
        S_CLEAR = 10'b1000000000
    } state_t;

    // configuration
    logic [8:0]         gw_reg, gh_reg;
    logic signed [31:0] ox_reg, oy_reg;
    logic [30:0]        cs_reg;
    logic [7:0]         fill_reg;

    state_t state_reg, state_next;

    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [MCW-1:0]  mcnt_reg, mcnt_next;
    logic [CWW-1:0]  x_reg, x_next;
    logic [RWW-1:0]  y_reg, y_next;
    logic [AW-1:0]   saddr_reg, saddr_next;
    logic signed [PW-1:0] py_reg, py_next;
    logic signed [33:0]   px0_reg, px0_next, py0_reg, py0_next;
    logic [31:0]     step_reg, step_next;
    logic [7:0]      zone_reg, zone_next;
    logic [AW-1:0]   qaddr_reg, qaddr_next;
    logic            qin_reg, qin_next;
    logic [3:0]      qdir_reg, qdir_next;

    logic        done_reg, done_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  mask_reg, mask_next;
    logic        allowed_reg, allowed_next;

    logic accept, add_fire;
    logic [GEW-1:0] gw_ext;
    logic [GHW-1:0] gh_ext;
    logic [CWW-1:0] w_eff;
    logic [RWW-1:0] h_eff;
    logic [QW-1:0]  qprod;
    logic           row_end, last_cell;

    // RAM
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata, ram_rdata;

    // edge chain
    pzdm_setup_t          setup;
    pzdm_tok_t            tok_c  [MAX_VERTICES+1];
    logic signed [PW-1:0] py_c   [MAX_VERTICES+1];
    logic [AW-1:0]        addr_c [MAX_VERTICES+1];
    pzdm_tok_t            tok_end;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign add_fire  = accept && (mode == MODE_ADD)
                     && (cnt_reg < CNTW'(MAX_VERTICES));
    assign cfg_ready = 1'b1;

    // clamp the configured size to the built grid
    assign gw_ext = GEW'(gw_reg);
    assign gh_ext = GHW'(gh_reg);
    assign w_eff  = (gw_ext < GEW'(MAX_COLUMNS)) ? CWW'(gw_ext) : CWW'(MAX_COLUMNS);
    assign h_eff  = (gh_ext < GHW'(MAX_ROWS)) ? RWW'(gh_ext) : RWW'(MAX_ROWS);

    assign qprod = QW'(cell_y) * QW'(w_eff) + QW'(cell_x);

    assign row_end   = (x_reg == w_eff - CWW'(1));
    assign last_cell = row_end && (y_reg == h_eff - RWW'(1));

    assign tok_end = tok_c[MAX_VERTICES];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg   <= RST_GRID_WIDTH;
            gh_reg   <= RST_GRID_HEIGHT;
            ox_reg   <= '0;
            oy_reg   <= '0;
            cs_reg   <= RST_CELL_SIZE;
            fill_reg <= RST_FILL_MASK;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  gw_reg   <= cfg_data[8:0];
                CFG_GRID_HEIGHT: gh_reg   <= cfg_data[8:0];
                CFG_ORIGIN_X:    ox_reg   <= cfg_data;
                CFG_ORIGIN_Y:    oy_reg   <= cfg_data;
                CFG_CELL_SIZE:   cs_reg   <= cfg_data[30:0];
                CFG_FILL_MASK:   fill_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        clr_next     = clr_reg;
        mcnt_next    = mcnt_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        saddr_next   = saddr_reg;
        py_next      = py_reg;
        px0_next     = px0_reg;
        py0_next     = py0_reg;
        step_next    = step_reg;
        zone_next    = zone_reg;
        qaddr_next   = qaddr_reg;
        qin_next     = qin_reg;
        qdir_next    = qdir_reg;
        done_next    = 1'b0;
        status_next  = STATUS_OK;
        mask_next    = '0;
        allowed_next = 1'b0;

        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = S_IDLE;
                    done_next  = (state_reg == S_CLEAR);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_ADD:
                        begin
                            done_next = 1'b1;
                            if (add_fire)
                            begin
                                cnt_next = cnt_reg + CNTW'(1);
                            end
                            else
                            begin
                                status_next = STATUS_FULL;
                            end
                        end

                        MODE_APPLY:
                        begin
                            zone_next  = zone_mask;
                            px0_next   = {ox_reg[31], ox_reg, 1'b0} + {3'b000, cs_reg};
                            py0_next   = {oy_reg[31], oy_reg, 1'b0} + {3'b000, cs_reg};
                            step_next  = {cs_reg, 1'b0};
                            py_next    = PW'(signed'({oy_reg[31], oy_reg, 1'b0}
                                                     + {3'b000, cs_reg}));
                            x_next     = '0;
                            y_next     = '0;
                            saddr_next = '0;
                            if (cnt_reg < CNTW'(MIN_VERTICES))
                            begin
                                done_next   = 1'b1;
                                status_next = STATUS_FEW;
                                cnt_next    = '0;
                            end
                            else if ((w_eff == '0) || (h_eff == '0))
                            begin
                                done_next = 1'b1;
                                cnt_next  = '0;
                            end
                            else
                            begin
                                state_next = S_LOAD;
                            end
                        end

                        MODE_QUERY:
                        begin
                            qaddr_next = qprod[AW-1:0];
                            qin_next   = (QW'(cell_x) < QW'(w_eff))
                                      && (QW'(cell_y) < QW'(h_eff));
                            qdir_next  = direction;
                            state_next = S_QREAD;
                        end

                        default:
                        begin
                            clr_next   = '0;
                            state_next = S_CLEAR;
                        end
                    endcase
                end
            end

            S_QREAD:
            begin
                state_next = S_QOUT;
            end

            S_QOUT:
            begin
                done_next    = 1'b1;
                mask_next    = qin_reg ? ram_rdata : 8'h00;
                allowed_next = qin_reg && (qdir_reg <= MAX_DIRECTION)
                            && ram_rdata[qdir_reg[2:0]];
                state_next   = S_IDLE;
            end

            S_LOAD:
            begin
                mcnt_next  = '0;
                state_next = S_MUL;
            end

            S_MUL:
            begin
                mcnt_next = mcnt_reg + MCW'(1);
                if (mcnt_reg == MCW'(MUL_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                state_next = S_SWEEP;
            end

            S_SWEEP:
            begin
                // walk the grid row by row, one cell per cycle
                saddr_next = saddr_reg + AW'(1);
                if (row_end)
                begin
                    x_next  = '0;
                    y_next  = y_reg + RWW'(1);
                    py_next = py_reg + PW'(step_reg);
                end
                else
                begin
                    x_next = x_reg + CWW'(1);
                end
                if (last_cell)
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                if (tok_end.valid && tok_end.last)
                begin
                    done_next  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_INIT;
            cnt_reg     <= '0;
            clr_reg     <= '0;
            mcnt_reg    <= '0;
            done_reg    <= 1'b0;
            status_reg  <= STATUS_OK;
            mask_reg    <= '0;
            allowed_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            clr_reg     <= clr_next;
            mcnt_reg    <= mcnt_next;
            done_reg    <= done_next;
            status_reg  <= status_next;
            mask_reg    <= mask_next;
            allowed_reg <= allowed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        saddr_reg <= saddr_next;
        py_reg    <= py_next;
        px0_reg   <= px0_next;
        py0_reg   <= py0_next;
        step_reg  <= step_next;
        zone_reg  <= zone_next;
        qaddr_reg <= qaddr_next;
        qin_reg   <= qin_next;
        qdir_reg  <= qdir_next;
    end

    // edge cell chain: feed one grid point per cycle in the sweep
    assign setup = '{load: (state_reg == S_LOAD),
                     step: (state_reg == S_MUL),
                     fin:  (state_reg == S_FIN)};

    assign tok_c[0]  = '{valid:   (state_reg == S_SWEEP),
                         row_end: row_end,
                         last:    last_cell,
                         parity:  1'b0};
    assign py_c[0]   = py_reg;
    assign addr_c[0] = saddr_reg;

    for (genvar k = 0; k < MAX_VERTICES; k++)
    begin : g_cell
        logic load_j;

        if (k == 0)
        begin : g_first
            // edge 0 closes the polygon: keep the latest vertex as its far end
            assign load_j = add_fire;
        end
        else
        begin : g_rest
            assign load_j = add_fire && (cnt_reg == CNTW'(k - 1));
        end

        pzdm_edge_cell #(
            .PW (PW),
            .LW (LW),
            .AW (AW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .active   (cnt_reg > CNTW'(k)),
            .vx       (vertex_x),
            .vy       (vertex_y),
            .load_i   (add_fire && (cnt_reg == CNTW'(k))),
            .load_j   (load_j),
            .px0      (px0_reg),
            .py0      (py0_reg),
            .step     (step_reg),
            .setup    (setup),
            .tok_in   (tok_c[k]),
            .py_in    (py_c[k]),
            .addr_in  (addr_c[k]),
            .tok_out  (tok_c[k+1]),
            .py_out   (py_c[k+1]),
            .addr_out (addr_c[k+1])
        );
    end

    // mask store: clear pass owns the write port, otherwise the chain output
    always_comb
    begin
        if ((state_reg == S_INIT) || (state_reg == S_CLEAR))
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = (state_reg == S_INIT) ? INIT_MASK : fill_reg;
        end
        else
        begin
            ram_we    = tok_end.valid && tok_end.parity;
            ram_waddr = addr_c[MAX_VERTICES];
            ram_wdata = zone_reg;
        end
    end

    pzdm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (qaddr_reg),
        .rdata (ram_rdata)
    );

    assign done      = done_reg;
    assign status    = status_reg;
    assign cell_mask = mask_reg;
    assign allowed   = allowed_reg;

endmodule

// ===== design/pzdm_ram.sv =====
// ----------------------------------------------------------------------------
// pzdm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pzdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/pzdm_edge_cell.sv =====
// ----------------------------------------------------------------------------
// pzdm_edge_cell
// One polygon edge: holds its vertices, builds its cross products with a
// serial multiplier, then tests each passing grid point and hands the
// running crossing parity to the next cell.
// ----------------------------------------------------------------------------
module pzdm_edge_cell
    import pzdm_pkg::*;
#(
    parameter int PW = 42,
    parameter int LW = 77,
    parameter int AW = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 active,
    input  logic signed [31:0]   vx,
    input  logic signed [31:0]   vy,
    input  logic                 load_i,
    input  logic                 load_j,
    input  logic signed [33:0]   px0,
    input  logic signed [33:0]   py0,
    input  logic [31:0]          step,
    input  pzdm_setup_t          setup,
    input  pzdm_tok_t            tok_in,
    input  logic signed [PW-1:0] py_in,
    input  logic [AW-1:0]        addr_in,
    output pzdm_tok_t            tok_out,
    output logic signed [PW-1:0] py_out,
    output logic [AW-1:0]        addr_out
);

    logic signed [31:0] xi_reg, yi_reg, xj_reg, yj_reg;

    logic signed [LW-1:0] ma_reg, mb_reg, ms_reg;
    logic [33:0]          dym_reg, dxm_reg;
    logic                 dyn_reg, dxn_reg;
    logic signed [LW-1:0] al0_reg, adl_reg, ar0_reg, adr_reg;
    logic signed [LW-1:0] l_reg, l0_reg, dl_reg, r_reg, dr_reg;

    pzdm_tok_t            tok_reg;
    logic signed [PW-1:0] py_reg;
    logic [AW-1:0]        addr_reg;

    logic signed [33:0]   dy, dx;
    logic signed [PW-1:0] yi_ext, yj_ext;
    logic                 span, less, flip;

    assign dy = {yj_reg[31], yj_reg, 1'b0} - {yi_reg[31], yi_reg, 1'b0};
    assign dx = {xj_reg[31], xj_reg, 1'b0} - {xi_reg[31], xi_reg, 1'b0};

    assign yi_ext = {{(PW-33){yi_reg[31]}}, yi_reg, 1'b0};
    assign yj_ext = {{(PW-33){yj_reg[31]}}, yj_reg, 1'b0};

    // edge straddles the point's row
    assign span = (yi_ext > py_in) != (yj_ext > py_in);
    assign less = dyn_reg ? (r_reg < l_reg) : (l_reg < r_reg);
    assign flip = active && span && less;

    always_ff @(posedge clk)
    begin
        if (load_i)
        begin
            xi_reg <= vx;
            yi_reg <= vy;
        end
        if (load_j)
        begin
            xj_reg <= vx;
            yj_reg <= vy;
        end

        if (setup.load)
        begin
            ma_reg  <= {{(LW-34){px0[33]}}, px0}
                     - {{(LW-33){xi_reg[31]}}, xi_reg, 1'b0};
            mb_reg  <= {{(LW-34){py0[33]}}, py0}
                     - {{(LW-33){yi_reg[31]}}, yi_reg, 1'b0};
            ms_reg  <= {{(LW-32){1'b0}}, step};
            dyn_reg <= dy[33];
            dxn_reg <= dx[33];
            dym_reg <= dy[33] ? -dy : dy;
            dxm_reg <= dx[33] ? -dx : dx;
            al0_reg <= '0;
            adl_reg <= '0;
            ar0_reg <= '0;
            adr_reg <= '0;
        end
        else if (setup.step)
        begin
            if (dym_reg[0])
            begin
                al0_reg <= al0_reg + ma_reg;
                adl_reg <= adl_reg + ms_reg;
            end
            if (dxm_reg[0])
            begin
                ar0_reg <= ar0_reg + mb_reg;
                adr_reg <= adr_reg + ms_reg;
            end
            ma_reg  <= ma_reg <<< 1;
            mb_reg  <= mb_reg <<< 1;
            ms_reg  <= ms_reg <<< 1;
            dym_reg <= dym_reg >> 1;
            dxm_reg <= dxm_reg >> 1;
        end
        else if (setup.fin)
        begin
            l_reg  <= dyn_reg ? -al0_reg : al0_reg;
            l0_reg <= dyn_reg ? -al0_reg : al0_reg;
            dl_reg <= dyn_reg ? -adl_reg : adl_reg;
            r_reg  <= dxn_reg ? -ar0_reg : ar0_reg;
            dr_reg <= dxn_reg ? -adr_reg : adr_reg;
        end
        else if (tok_in.valid)
        begin
            // advance along the row; rewind at its end and step R to the next row
            if (tok_in.row_end)
            begin
                l_reg <= l0_reg;
                r_reg <= r_reg + dr_reg;
            end
            else
            begin
                l_reg <= l_reg + dl_reg;
            end
        end

        py_reg   <= py_in;
        addr_reg <= addr_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= '{valid:   tok_in.valid,
                         row_end: tok_in.row_end,
                         last:    tok_in.last,
                         parity:  tok_in.parity ^ flip};
        end
    end

    assign tok_out  = tok_reg;
    assign py_out   = py_reg;
    assign addr_out = addr_reg;

endmodule

// ===== design/pzdm_checker.sv =====
// ----------------------------------------------------------------------------
// pzdm_checker
// Port-level checks of the direction mask grid, bound to the top level.
// ----------------------------------------------------------------------------
module pzdm_checker
    import pzdm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [1:0] status,
    input logic [7:0] cell_mask,
    input logic       allowed
);

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == STATUS_OK || status == STATUS_FEW
                  || status == STATUS_FULL))
        else $error("status code out of range");

    a_error_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (cell_mask == 8'h00 && !allowed))
        else $error("failed request carries a mask");

    a_allowed_needs_mask: assert property (@(posedge clk) disable iff (!rst_n)
        allowed |-> (done && cell_mask != 8'h00))
        else $error("allowed without a set mask bit");

    a_request_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted request neither working nor answered");

endmodule

bind polygon_zone_direction_mask_grid_core pzdm_checker u_pzdm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .cell_mask (cell_mask),
    .allowed   (allowed)
);
